>>> sv/shortest_path_single_source_top_macros.svh
// Assertion macros shared by the checker of the shortest path block.
// Depends on a clock i_clk and an active-low reset i_rst_n in the using scope.
`ifndef SHORTEST_PATH_SINGLE_SOURCE_TOP_MACROS_SVH
`define SHORTEST_PATH_SINGLE_SOURCE_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SSSP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sssp port check failed");

// Next-cycle implication, disabled during reset.
`define SSSP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sssp port check failed");

`endif

>>> sv/sssp_pkg.sv
// Package of the shortest path block: input mode codes, configuration
// register indexes, node status codes and the controller state type.
package sssp_pkg;

    // Input item modes.
    localparam logic [1:0] MODE_WR_DIR  = 2'd0;
    localparam logic [1:0] MODE_WR_BOTH = 2'd1;
    localparam logic [1:0] MODE_RUN     = 2'd2;

    // Configuration register indexes.
    localparam logic CFG_NODE_COUNT = 1'b0;
    localparam logic CFG_SOURCE     = 1'b1;

    // Saturation value of distances.
    localparam logic [21:0] DIST_MAX = 22'h3FFFFF;

    // Per-node status kept in the node memory.
    typedef enum logic [1:0] {
        NS_UNVISITED = 2'd0,
        NS_FRONTIER  = 2'd1,
        NS_SETTLED   = 2'd2
    } t_status;

    // Controller states.
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WRITE2,
        ST_RUN_CLEAR,
        ST_INIT,
        ST_SELECT,
        ST_SETTLE,
        ST_RELAX,
        ST_OUT_READ,
        ST_OUT_LOAD,
        ST_OUT_HOLD
    } t_state;

endpackage

>>> sv/shortest_path_single_source_top.sv
// Dijkstra shortest paths over an adjacency matrix held in block memory.
// Edge writes go straight to the matrix; a write in both directions writes
// the reverse entry from a second state. A run clears the status of the
// nodes in use, then per settled node scans the node memory for the minimum
// and makes a relax pass over one matrix row, then gives one result per node.
// After reset a clearing pass empties the matrix.
module shortest_path_single_source_top #(
    parameter int MAX_NODES   = 64,
    parameter int WEIGHT_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [6:0]  i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_mode,
    input  logic [5:0]  i_src_node,
    input  logic [5:0]  i_dst_node,
    input  logic signed [16:0] i_weight,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [5:0]  o_node,
    output logic [5:0]  o_predecessor,
    output logic        o_reached,
    output logic [21:0] o_path_length,
    output logic        o_last
);
    import sssp_pkg::*;

    localparam int NB    = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int EDEP  = MAX_NODES * MAX_NODES;
    localparam int AB    = $clog2(EDEP);
    localparam int NW    = 22 + NB + 2;
    localparam int EW    = WEIGHT_BITS + 1;
    localparam logic [WEIGHT_BITS-1:0] WMAX = '1;

    // Memories: matrix entries {present, weight} and node entries
    // {distance, predecessor, status}.
    logic [EW-1:0] edge_mem [EDEP];
    logic [NW-1:0] node_mem [MAX_NODES];
    logic          em_we;
    logic [AB-1:0] em_wa, em_ra;
    logic [EW-1:0] em_wd, em_q;
    logic          nm_we;
    logic [NB-1:0] nm_wa, nm_ra;
    logic [NW-1:0] nm_wd, nm_q;

    always_ff @(posedge i_clk) begin
        if (em_we) begin
            edge_mem[em_wa] <= em_wd;
        end
        em_q <= edge_mem[em_ra];
    end

    always_ff @(posedge i_clk) begin
        if (nm_we) begin
            node_mem[nm_wa] <= nm_wd;
        end
        nm_q <= node_mem[nm_ra];
    end

    // Registers.
    t_state         r_state, n_state;
    logic [AB:0]    r_ec, n_ec;
    logic [6:0]     r_nc, n_nc;
    logic [5:0]     r_sn, n_sn;
    logic [NB:0]    r_n, n_n;
    logic [NB:0]    r_i, n_i;
    logic           r_rv, n_rv;
    logic [NB-1:0]  r_ri, n_ri;
    logic [NB-1:0]  r_src, n_src;
    logic           r_src_ok, n_src_ok;
    logic [NB-1:0]  r_u, n_u;
    logic [21:0]    r_du, n_du;
    logic [NB-1:0]  r_pu, n_pu;
    logic           r_found, n_found;
    logic [21:0]    r_bd, n_bd;
    logic [NB-1:0]  r_bi, n_bi;
    logic [NB-1:0]  r_bp, n_bp;
    logic [AB-1:0]  r_wa2, n_wa2;
    logic [EW-1:0]  r_wd2, n_wd2;
    logic           r_ov, n_ov;
    logic [5:0]     r_o_node, n_o_node;
    logic [5:0]     r_o_pred, n_o_pred;
    logic           r_o_reached, n_o_reached;
    logic [21:0]    r_o_len, n_o_len;
    logic           r_o_last, n_o_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLEAR;
            r_ec     <= '0;
            r_nc     <= 7'd64;
            r_sn     <= 6'd0;
            r_i      <= '0;
            r_rv     <= 1'b0;
            r_found  <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ec     <= n_ec;
            r_nc     <= n_nc;
            r_sn     <= n_sn;
            r_i      <= n_i;
            r_rv     <= n_rv;
            r_found  <= n_found;
            r_ov     <= n_ov;
        end
    end

    // Payload and working registers need no reset.
    always_ff @(posedge i_clk) begin
        r_n         <= n_n;
        r_ri        <= n_ri;
        r_src       <= n_src;
        r_src_ok    <= n_src_ok;
        r_u         <= n_u;
        r_du        <= n_du;
        r_pu        <= n_pu;
        r_bd        <= n_bd;
        r_bi        <= n_bi;
        r_bp        <= n_bp;
        r_wa2       <= n_wa2;
        r_wd2       <= n_wd2;
        r_o_node    <= n_o_node;
        r_o_pred    <= n_o_pred;
        r_o_reached <= n_o_reached;
        r_o_len     <= n_o_len;
        r_o_last    <= n_o_last;
    end

    // Fields of the node memory read data.
    logic [21:0]   q_dist;
    logic [NB-1:0] q_prev;
    t_status       q_st;
    assign q_dist = nm_q[NW-1 -: 22];
    assign q_prev = nm_q[NB+1:2];
    assign q_st   = t_status'(nm_q[1:0]);

    // Edge write decode from the input ports.
    logic          w_ok;
    logic [31:0]   w_val;
    logic [WEIGHT_BITS-1:0] w_sat;
    logic [EW-1:0] w_word;
    logic [AB-1:0] w_ab, w_ba;
    assign w_ok   = (32'(i_src_node) < 32'(MAX_NODES)) && (32'(i_dst_node) < 32'(MAX_NODES));
    assign w_val  = 32'(i_weight[15:0]);
    assign w_sat  = (w_val > 32'(WMAX)) ? WMAX : WEIGHT_BITS'(w_val);
    assign w_word = {~i_weight[16], w_sat};
    assign w_ab   = AB'(AB'(NB'(i_src_node)) * AB'(MAX_NODES) + AB'(NB'(i_dst_node)));
    assign w_ba   = AB'(AB'(NB'(i_dst_node)) * AB'(MAX_NODES) + AB'(NB'(i_src_node)));

    // Nodes in use for a run.
    logic [31:0] n_use;
    always_comb begin
        n_use = (r_nc == 7'd0) ? 32'd1 : 32'(r_nc);
        if (n_use > 32'(MAX_NODES)) begin
            n_use = 32'(MAX_NODES);
        end
    end

    // Minimum scan over the frontier: strict compare keeps the lowest index.
    logic take;
    assign take = r_rv && (q_st == NS_FRONTIER) && (!r_found || (q_dist < r_bd));

    // Relaxation of one edge of the settled node.
    logic [32:0] sum;
    logic [21:0] nd;
    logic        relax;
    assign sum   = 33'(r_du) + 33'(em_q[WEIGHT_BITS-1:0]);
    assign nd    = (sum > 33'(DIST_MAX)) ? DIST_MAX : sum[21:0];
    assign relax = r_rv && em_q[WEIGHT_BITS] && (q_st != NS_SETTLED) &&
                   ((q_st == NS_UNVISITED) || (nd < q_dist));

    logic [31:0] k_ext, p_ext;
    assign k_ext = 32'(r_i);
    assign p_ext = 32'(q_prev);

    // Next state, memory control and outputs.
    always_comb begin
        n_state = r_state;
        n_ec = r_ec;
        n_nc = r_nc;
        n_sn = r_sn;
        n_n = r_n;
        n_i = r_i;
        n_rv = 1'b0;
        n_ri = r_ri;
        n_src = r_src;
        n_src_ok = r_src_ok;
        n_u = r_u;
        n_du = r_du;
        n_pu = r_pu;
        n_found = r_found;
        n_bd = r_bd;
        n_bi = r_bi;
        n_bp = r_bp;
        n_wa2 = r_wa2;
        n_wd2 = r_wd2;
        n_ov = r_ov;
        n_o_node = r_o_node;
        n_o_pred = r_o_pred;
        n_o_reached = r_o_reached;
        n_o_len = r_o_len;
        n_o_last = r_o_last;
        em_we = 1'b0;
        em_wa = w_ab;
        em_wd = w_word;
        em_ra = AB'(AB'(r_u) * AB'(MAX_NODES) + AB'(r_i[NB-1:0]));
        nm_we = 1'b0;
        nm_wa = r_ri;
        nm_wd = {nd, r_u, NS_FRONTIER};
        nm_ra = r_i[NB-1:0];
        o_in_ready = 1'b0;

        // Configuration writes are taken in any state.
        if (i_cfg_we) begin
            if (i_cfg_idx == CFG_NODE_COUNT) begin
                n_nc = i_cfg_data;
            end else begin
                n_sn = i_cfg_data[5:0];
            end
        end

        unique case (r_state)
            // Clearing pass over the matrix after reset.
            ST_CLEAR: begin
                em_we = 1'b1;
                em_wa = r_ec[AB-1:0];
                em_wd = '0;
                n_ec = r_ec + 1'b1;
                if (32'(r_ec) == 32'(EDEP - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    priority if (i_mode == MODE_WR_DIR) begin
                        em_we = w_ok;
                    end else if (i_mode == MODE_WR_BOTH) begin
                        em_we = w_ok;
                        n_wa2 = w_ba;
                        n_wd2 = w_word;
                        if (w_ok) begin
                            n_state = ST_WRITE2;
                        end
                    end else if (i_mode == MODE_RUN) begin
                        n_n = (NB+1)'(n_use);
                        n_src = NB'(r_sn);
                        n_src_ok = 32'(r_sn) < n_use;
                        n_i = '0;
                        n_state = ST_RUN_CLEAR;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_WRITE2: begin
                em_we = 1'b1;
                em_wa = r_wa2;
                em_wd = r_wd2;
                n_state = ST_IDLE;
            end
            // Per-run status clear over the nodes in use.
            ST_RUN_CLEAR: begin
                nm_we = 1'b1;
                nm_wa = r_i[NB-1:0];
                nm_wd = {22'd0, NB'(0), NS_UNVISITED};
                n_i = r_i + 1'b1;
                if (r_i == r_n - 1'b1) begin
                    n_i = '0;
                    n_state = r_src_ok ? ST_INIT : ST_OUT_READ;
                end
            end
            ST_INIT: begin
                nm_we = 1'b1;
                nm_wa = r_src;
                nm_wd = {22'd0, r_src, NS_FRONTIER};
                n_i = '0;
                n_found = 1'b0;
                n_state = ST_SELECT;
            end
            // Scan the node memory for the closest frontier node.
            ST_SELECT: begin
                if (r_i < r_n) begin
                    n_rv = 1'b1;
                    n_ri = r_i[NB-1:0];
                    n_i = r_i + 1'b1;
                end
                if (take) begin
                    n_found = 1'b1;
                    n_bd = q_dist;
                    n_bi = r_ri;
                    n_bp = q_prev;
                end
                if ((r_i == r_n) && r_rv) begin
                    n_rv = 1'b0;
                    n_i = '0;
                    if (r_found || take) begin
                        n_u  = take ? r_ri : r_bi;
                        n_du = take ? q_dist : r_bd;
                        n_pu = take ? q_prev : r_bp;
                        n_state = ST_SETTLE;
                    end else begin
                        n_state = ST_OUT_READ;
                    end
                end
            end
            ST_SETTLE: begin
                nm_we = 1'b1;
                nm_wa = r_u;
                nm_wd = {r_du, r_pu, NS_SETTLED};
                n_i = '0;
                n_state = ST_RELAX;
            end
            // Walk the row of the settled node; write back improved entries.
            ST_RELAX: begin
                if (r_i < r_n) begin
                    n_rv = 1'b1;
                    n_ri = r_i[NB-1:0];
                    n_i = r_i + 1'b1;
                end
                nm_we = relax;
                if ((r_i == r_n) && r_rv) begin
                    n_rv = 1'b0;
                    n_i = '0;
                    n_found = 1'b0;
                    n_state = ST_SELECT;
                end
            end
            ST_OUT_READ: begin
                n_state = ST_OUT_LOAD;
            end
            ST_OUT_LOAD: begin
                n_ov = 1'b1;
                n_o_node = k_ext[5:0];
                n_o_reached = r_src_ok && (q_st == NS_SETTLED);
                n_o_pred = n_o_reached ? p_ext[5:0] : 6'd0;
                n_o_len = n_o_reached ? q_dist : DIST_MAX;
                n_o_last = (r_i == r_n - 1'b1);
                n_state = ST_OUT_HOLD;
            end
            ST_OUT_HOLD: begin
                if (i_out_ready) begin
                    n_ov = 1'b0;
                    if (r_i == r_n - 1'b1) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_i = r_i + 1'b1;
                        n_state = ST_OUT_READ;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_out_valid   = r_ov;
    assign o_node        = r_o_node;
    assign o_predecessor = r_o_pred;
    assign o_reached     = r_o_reached;
    assign o_path_length = r_o_len;
    assign o_last        = r_o_last;

endmodule

>>> sv/sssp_checker.sv
// Port-level checker of the shortest path block and its bind statement.
// Depends on the assertion macros header.
`include "shortest_path_single_source_top_macros.svh"

module sssp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [5:0]  o_node,
    input logic [5:0]  o_predecessor,
    input logic        o_reached,
    input logic [21:0] o_path_length,
    input logic        o_last
);
    // No new transaction is taken while a result is pending.
    `SSSP_ASSERT_NOW(a_busy_out, o_out_valid, !o_in_ready)
    // An unreached node reports the saturated distance and predecessor zero.
    `SSSP_ASSERT_NOW(a_unreached, o_out_valid && !o_reached, (o_path_length == 22'h3FFFFF) && (o_predecessor == 6'd0))
    // The final result of a run is followed by an idle output.
    `SSSP_ASSERT_NEXT(a_last_ends, o_out_valid && i_out_ready && o_last, !o_out_valid)
    // A stalled result holds its payload.
    `SSSP_ASSERT_NEXT(a_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_node) && $stable(o_path_length))
endmodule

bind shortest_path_single_source_top sssp_checker u_sssp_checker (.*);
